/* rtl/core/stki_pkg.sv */
// ----------------------------------------------------------------------------
// stki_pkg
// Types and codes shared by the ranked distinct list blocks.
// ----------------------------------------------------------------------------
package stki_pkg;

   // fixed payload widths
   localparam int VALUE_W = 31;
   localparam int SLOT_W  = 4;
   localparam int STS_W   = 2;

   // result status codes
   localparam logic [STS_W-1:0] STS_INSERTED  = 2'd0;
   localparam logic [STS_W-1:0] STS_DUPLICATE = 2'd1;
   localparam logic [STS_W-1:0] STS_DROPPED   = 2'd2;
   localparam logic [STS_W-1:0] STS_READ      = 2'd3;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // request payload
   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] value;
      logic [SLOT_W-1:0]  slot_index;
   } req_type;

   // result payload
   typedef struct packed {
      logic [STS_W-1:0]   status;
      logic [SLOT_W-1:0]  position;
      logic [VALUE_W-1:0] read_value;
      logic               read_valid;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PRIME,
      ST_SHIFT,
      ST_COMMIT,
      ST_READ,
      ST_RDOUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic             load;
      logic             scan;
      logic             hit_capture;
      logic             prime;
      logic             step;
      logic             commit;
      logic             rd_slot;
      logic             emit;
      logic [STS_W-1:0] code;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic cmp_vld;
      logic dup;
      logic open;
      logic at_last;
      logic step_done;
   } stat_type;

endpackage

/* rtl/core/stki_ctrl.sv */
// ----------------------------------------------------------------------------
// stki_ctrl
// Sequencer for scan, shift and commit of an insert, and for slot reads.
// ----------------------------------------------------------------------------
module stki_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_func,
   input  stki_pkg::stat_type stat,
   output stki_pkg::cmd_type  cmd,
   output logic              busy
);

   stki_pkg::state_type state_ff;
   stki_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stki_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         stki_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_func == stki_pkg::FUNC_READ) ? stki_pkg::ST_READ
                                                             : stki_pkg::ST_SCAN;
            end
         end
         stki_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.cmp_vld) begin
               if (stat.dup) begin
                  cmd.scan = 1'b0;
                  cmd.emit = 1'b1;
                  cmd.code = stki_pkg::STS_DUPLICATE;
                  state_in = stki_pkg::ST_IDLE;
               end else if (stat.open) begin
                  cmd.scan        = 1'b0;
                  cmd.hit_capture = 1'b1;
                  state_in = stat.at_last ? stki_pkg::ST_COMMIT : stki_pkg::ST_PRIME;
               end else if (stat.at_last) begin
                  cmd.scan = 1'b0;
                  cmd.emit = 1'b1;
                  cmd.code = stki_pkg::STS_DROPPED;
                  state_in = stki_pkg::ST_IDLE;
               end
            end
         end
         stki_pkg::ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = stki_pkg::ST_SHIFT;
         end
         stki_pkg::ST_SHIFT: begin
            cmd.step = 1'b1;
            if (stat.step_done) begin
               state_in = stki_pkg::ST_COMMIT;
            end
         end
         stki_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.emit   = 1'b1;
            cmd.code   = stki_pkg::STS_INSERTED;
            state_in   = stki_pkg::ST_IDLE;
         end
         stki_pkg::ST_READ: begin
            cmd.rd_slot = 1'b1;
            state_in    = stki_pkg::ST_RDOUT;
         end
         stki_pkg::ST_RDOUT: begin
            cmd.rd_slot = 1'b1;
            cmd.emit    = 1'b1;
            cmd.code    = stki_pkg::STS_READ;
            state_in    = stki_pkg::ST_IDLE;
         end
         default: begin
            state_in = stki_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/stki_dpath.sv */
// ----------------------------------------------------------------------------
// stki_dpath
// Value memory, slot flags, scan compare, shift pointer and result register.
// ----------------------------------------------------------------------------
module stki_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stki_pkg::cmd_type                  cmd,
   input  stki_pkg::req_type                  req_data,
   input  logic [stki_pkg::SLOT_W-1:0]        last_index,
   output stki_pkg::stat_type                 stat,
   output logic                               rsp_valid,
   output stki_pkg::rsp_type                  rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // value store, one write and one registered read port
   logic [stki_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [stki_pkg::VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]             rd_addr;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [stki_pkg::VALUE_W-1:0] wr_data;

   // transaction registers
   logic [stki_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [stki_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]             last_ff, last_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]             hit_ff, hit_in;
   logic [DEPTH-1:0]             filled_ff, filled_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   stki_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]             slot_idx;
   logic                         slot_ok;
   logic                         rd_hit;
   stki_pkg::rsp_type            rsp_new;

   // slot of a read request
   assign slot_idx = IDX_W'(slot_ff);
   assign slot_ok  = ({28'd0, slot_ff} < 32'(DEPTH));

   // memory address and write selection
   always_comb begin
      if (cmd.rd_slot) begin
         rd_addr = slot_idx;
      end else if (cmd.prime) begin
         rd_addr = idx_ff - IDX_W'(1);
      end else if (cmd.step) begin
         rd_addr = idx_ff - IDX_W'(2);
      end else begin
         rd_addr = idx_ff;
      end
      wr_en   = cmd.step | cmd.commit;
      wr_addr = cmd.commit ? hit_ff : idx_ff;
      wr_data = cmd.commit ? value_ff : rd_data_ff;
   end

   // memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // scan status
   always_comb begin
      stat.cmp_vld   = cmp_vld_ff;
      stat.dup       = filled_ff[cmp_idx_ff] && (rd_data_ff == value_ff);
      stat.open      = !filled_ff[cmp_idx_ff] || (rd_data_ff < value_ff);
      stat.at_last   = (cmp_idx_ff == last_ff);
      stat.step_done = ((idx_ff - IDX_W'(1)) == hit_ff);
   end

   // result composition
   always_comb begin
      rd_hit              = slot_ok && filled_ff[slot_idx];
      rsp_new             = '0;
      rsp_new.status      = cmd.code;
      case (cmd.code)
         stki_pkg::STS_DUPLICATE: rsp_new.position = stki_pkg::SLOT_W'(cmp_idx_ff);
         stki_pkg::STS_INSERTED:  rsp_new.position = stki_pkg::SLOT_W'(hit_ff);
         stki_pkg::STS_READ: begin
            rsp_new.read_valid = rd_hit;
            rsp_new.read_value = rd_hit ? rd_data_ff : '0;
         end
         default: rsp_new.position = '0;
      endcase
   end

   // next values
   always_comb begin
      value_in     = value_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      filled_in    = filled_ff;
      cmp_vld_in   = cmd.scan;
      rsp_valid_in = cmd.emit;
      rsp_data_in  = cmd.emit ? rsp_new : rsp_data_ff;

      if (cmd.load) begin
         value_in = req_data.value;
         slot_in  = req_data.slot_index;
         idx_in   = '0;
         if ({28'd0, last_index} > 32'(DEPTH - 1)) begin
            last_in = IDX_W'(DEPTH - 1);
         end else begin
            last_in = IDX_W'(last_index);
         end
      end

      if (cmd.hit_capture) begin
         hit_in = cmp_idx_ff;
         idx_in = last_ff;
      end else if (cmd.scan) begin
         idx_in     = idx_ff + IDX_W'(1);
         cmp_idx_in = idx_ff;
      end else if (cmd.step) begin
         idx_in = idx_ff - IDX_W'(1);
      end

      // slot flags move down with their values
      if (cmd.commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) == hit_ff) begin
               filled_in[i] = 1'b1;
            end else if ((IDX_W'(i) > hit_ff) && (IDX_W'(i) <= last_ff) && (i > 0)) begin
               filled_in[i] = filled_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/sorted_distinct_topk_insert.sv */
// ----------------------------------------------------------------------------
// sorted_distinct_topk_insert
// Descending list of distinct values with insert and slot read transactions.
// ----------------------------------------------------------------------------
// an insert scans the list one slot per cycle, at most up to the kept last index,
//   then shifts the slots below the chosen place down one slot per cycle through
//   the value memory, which has one write and one registered read port
// start is taken when busy is low, so a new transaction waits for the last one
// reset: synchronous, all slots empty, last index 15; results cannot stall
module sorted_distinct_topk_insert #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  stki_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   output stki_pkg::rsp_type rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [1:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [stki_pkg::SLOT_W-1:0] last_index_ff, last_index_in;
   logic                        csr_wr;
   logic                        csr_reg_sel;
   stki_pkg::cmd_type           cmd;
   stki_pkg::stat_type          stat;

   // register write, single register at word zero
   assign csr_reg_sel   = (csr_paddr[1:0] == 2'd0);
   assign csr_wr        = csr_psel & csr_penable & csr_pwrite & csr_reg_sel;
   assign last_index_in = csr_wr ? csr_pwdata[stki_pkg::SLOT_W-1:0] : last_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff <= 4'd15;
      end else begin
         last_index_ff <= last_index_in;
      end
   end

   assign csr_prdata = {28'd0, last_index_ff};
   assign csr_pready = 1'b1;

   // controller
   stki_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath
   stki_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .last_index (last_index_ff),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

/* verif/tb_sorted_distinct_topk_insert.sv */
// ----------------------------------------------------------------------------
// tb_sorted_distinct_topk_insert
// Self-checking bench for the ranked distinct list. A shadow copy of the list
// and of the last index predicts every result; insert and read transactions
// are directed first, then random ones aimed at the gaps, the duplicates and
// the tail of the list under several list lengths and request gap rates.
// ----------------------------------------------------------------------------
module tb_sorted_distinct_topk_insert;
   import stki_pkg::*;

   localparam int SLOTS       = 16;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 24;
   localparam logic [1:0] ADDR_LAST_INDEX = 2'd0;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   logic        clock;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        busy;
   req_type     req_data    = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [1:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the ranked list and its length register
   logic [VALUE_W-1:0] shadow_rank [SLOTS];
   logic               shadow_held [SLOTS];
   logic [SLOT_W-1:0]  shadow_last = 4'd15;

   req_type pending_req [$];
   rsp_type expected_rsp [$];
   int      idle_pct     = 28;
   int      error_count  = 0;
   int      stall_cycles = 0;

   sorted_distinct_topk_insert dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         shadow_rank[k] = '0;
         shadow_held[k] = 1'b0;
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= 200)
         $display("ERROR %0t: %s: got %0h expected %0h", $time, what, got, want);
   endtask

   // apply one transaction to the shadow list and return its result
   function automatic rsp_type rank_update(req_type r);
      rsp_type     o;
      int          k;
      int          hit;
      bit          done;
      bit          dup;
      o = '0;
      if (r.func == FUNC_READ) begin
         o.status = STS_READ;
         if (shadow_held[r.slot_index]) begin
            o.read_value = shadow_rank[r.slot_index];
            o.read_valid = 1'b1;
         end
         return o;
      end
      done = 1'b0;
      dup  = 1'b0;
      hit  = 0;
      // first slot that is empty, smaller or equal
      for (k = 0; k <= int'(shadow_last) && !done; k++) begin
         if (shadow_held[k] && shadow_rank[k] == r.value) begin
            done = 1'b1;
            dup  = 1'b1;
            hit  = k;
         end else if (!shadow_held[k] || shadow_rank[k] < r.value) begin
            done = 1'b1;
            hit  = k;
         end
      end
      if (dup) begin
         o.status   = STS_DUPLICATE;
         o.position = SLOT_W'(hit);
      end else if (!done) begin
         o.status = STS_DROPPED;
      end else begin
         for (k = int'(shadow_last); k > hit; k--) begin
            shadow_rank[k] = shadow_rank[k-1];
            shadow_held[k] = shadow_held[k-1];
         end
         shadow_rank[hit] = r.value;
         shadow_held[hit] = 1'b1;
         o.status   = STS_INSERTED;
         o.position = SLOT_W'(hit);
      end
      return o;
   endfunction

   function automatic req_type make_req(logic f, logic [VALUE_W-1:0] v, int s);
      req_type r;
      r.func       = f;
      r.value      = v;
      r.slot_index = SLOT_W'(s);
      return r;
   endfunction

   // random transaction shaped by the current shadow list
   function automatic req_type next_request();
      req_type     r;
      int          pick;
      int          j;
      longint      lo;
      longint      up;
      r.func       = FUNC_INSERT;
      r.value      = VALUE_W'($urandom);
      r.slot_index = SLOT_W'($urandom_range(SLOTS - 1, 0));
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
         r.func = FUNC_READ;
      end else if (pick < 40) begin
         // fall between two neighbors so it lands at a chosen slot
         j  = $urandom_range(int'(shadow_last), 0);
         up = (j > 0 && shadow_held[j-1]) ? longint'(shadow_rank[j-1]) : (64'd1 << VALUE_W);
         lo = shadow_held[j] ? longint'(shadow_rank[j]) : -1;
         if (up - lo >= 2)
            r.value = VALUE_W'(lo + 1 + (longint'($urandom) % (up - lo - 1)));
      end else if (pick < 55) begin
         // repeat a held value, past the last slot too
         j = $urandom_range(SLOTS - 1, 0);
         if (shadow_held[j])
            r.value = shadow_rank[j];
      end else if (pick < 67) begin
         // aim below the tail of the list
         if (shadow_held[shadow_last] && shadow_rank[shadow_last] != '0)
            r.value = VALUE_W'(longint'($urandom) % longint'(shadow_rank[shadow_last]));
         else
            r.value = '0;
      end else if (pick >= 85) begin
         case ($urandom_range(3, 0))
            0:       r.value = '0;
            1:       r.value = VALUE_W'(1);
            2:       r.value = VALUE_MAX;
            default: r.value = VALUE_MAX - 1'b1;
         endcase
      end
      return r;
   endfunction

   // wait until the block is done with everything sent, then let it settle
   task automatic drain();
      while (pending_req.size() != 0 || start || expected_rsp.size() != 0 || busy)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write the last index, then read it back
   task automatic write_last_index(logic [SLOT_W-1:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_LAST_INDEX;
      csr_pwdata  <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_last = v;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== 32'(v))
         report_mismatch("last index readback", csr_prdata, 32'(v));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_rsp.push_back(rank_update(req_data));
         if (!start || !busy) begin
            if (pending_req.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
               start    <= 1'b1;
               req_data <= pending_req.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_data, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.position !== want.position)
               report_mismatch("position", rsp_data.position, want.position);
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
            if (rsp_data.read_valid !== want.read_valid)
               report_mismatch("read_valid", rsp_data.read_valid, want.read_valid);
         end
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      logic [SLOT_W-1:0] phase_last [12];
      int                p;
      int                n;
      phase_last = '{4'd15, 4'd3, 4'd1, 4'd0, 4'd7, 4'd15,
                     4'd10, 4'd2, 4'd15, 4'd5, 4'd12, 4'd15};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty reads, extremes, duplicates and ordering at full length
      pending_req.push_back(make_req(FUNC_READ, '0, 0));
      pending_req.push_back(make_req(FUNC_READ, VALUE_MAX, 15));
      pending_req.push_back(make_req(FUNC_INSERT, '0, 15));
      pending_req.push_back(make_req(FUNC_INSERT, '0, 0));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_MAX, 0));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_MAX, 15));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(1), 5));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(100), 10));
      for (int k = 0; k < 4; k++)
         pending_req.push_back(make_req(FUNC_READ, VALUE_W'(k), k));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(1), 2));
      drain();

      // two-slot list: overwrite the last slot, read past it and repeat a held value
      write_last_index(4'd1);
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(50), 0));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(200), 0));
      pending_req.push_back(make_req(FUNC_READ, '0, 1));
      pending_req.push_back(make_req(FUNC_READ, '0, 2));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_MAX, 0));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(200), 0));
      drain();

      // one-slot list
      write_last_index(4'd0);
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_W'(5), 0));
      pending_req.push_back(make_req(FUNC_INSERT, VALUE_MAX, 0));
      pending_req.push_back(make_req(FUNC_READ, '0, 0));
      drain();

      // random phases over several list lengths and gap rates
      for (p = 0; p < 12; p++) begin
         idle_pct = (p < 4) ? 28 : (p < 8) ? 87 : 0;
         write_last_index(phase_last[p]);
         for (n = 0; n < 110; n++) begin
            @(negedge clock);
            while (pending_req.size() != 0)
               @(negedge clock);
            pending_req.push_back(next_request());
         end
         drain();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/stki_pkg.sv
rtl/core/stki_ctrl.sv
rtl/core/stki_dpath.sv
rtl/core/sorted_distinct_topk_insert.sv
verif/tb_sorted_distinct_topk_insert.sv
